// ===== rtl/core/spas_pkg.sv =====
// Shared types, register indexes and code decoding for the slice allocation stepper.
package spas_pkg;

   // Field and count widths.
   localparam int unsigned COUNT_W = 10;
   localparam int unsigned CODE_W  = 5;
   localparam int unsigned SUM_W   = COUNT_W + 2;
   localparam int unsigned SLICES  = 3;
   localparam int unsigned CSR_IDX_W = 2;

   // Count limits and the first code that is rejected.
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 10'd1023;
   localparam logic [COUNT_W-1:0] COUNT_MIN  = 10'd1;
   localparam logic [CODE_W-1:0]  CODE_LIMIT = 5'd27;

   // Reset values of the configuration registers.
   localparam logic [COUNT_W-1:0] TOTAL_RESET  = 10'd100;
   localparam logic [COUNT_W-1:0] FIRST_RESET  = 10'd34;
   localparam logic [COUNT_W-1:0] SECOND_RESET = 10'd33;
   localparam logic [COUNT_W-1:0] THIRD_RESET  = 10'd33;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THIRD  = 2'd3;

   // Base-3 digit meanings.
   localparam logic [1:0] DIGIT_DEC  = 2'd0;
   localparam logic [1:0] DIGIT_HOLD = 2'd1;
   localparam logic [1:0] DIGIT_INC  = 2'd2;

   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [SLICES-1:0][1:0] digits_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic apply;
      logic step;
      logic capture;
   } spas_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic code_ok;
      logic bal_done;
   } spas_status_type;

   // Split a code below 27 into its base-3 digits; entry 0 is the first slice.
   function automatic digits_type decode_code(input logic [CODE_W-1:0] code);
      digits_type            d;
      logic [CODE_W-1:0]     rem;
      d   = '0;
      rem = code;
      if (rem >= 5'd18) begin
         d[0] = DIGIT_INC;
         rem  = rem - 5'd18;
      end else if (rem >= 5'd9) begin
         d[0] = DIGIT_HOLD;
         rem  = rem - 5'd9;
      end else begin
         d[0] = DIGIT_DEC;
      end
      if (rem >= 5'd6) begin
         d[1] = DIGIT_INC;
         rem  = rem - 5'd6;
      end else if (rem >= 5'd3) begin
         d[1] = DIGIT_HOLD;
         rem  = rem - 5'd3;
      end else begin
         d[1] = DIGIT_DEC;
      end
      d[2] = rem[1:0];
      return d;
   endfunction

endpackage

// ===== rtl/core/spas_datapath.sv =====
// Datapath: configuration registers, slice counts, one-block rebalancing and result registers.
module spas_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [spas_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [spas_pkg::COUNT_W-1:0]        csr_wdata,
   input  logic [spas_pkg::CODE_W-1:0]         req_action_code,
   input  spas_pkg::spas_cmd_type              cmd,
   output spas_pkg::spas_status_type           status,
   output logic                                rsp_accepted,
   output logic [spas_pkg::COUNT_W-1:0]        rsp_count_first,
   output logic [spas_pkg::COUNT_W-1:0]        rsp_count_second,
   output logic [spas_pkg::COUNT_W-1:0]        rsp_count_third
);
   import spas_pkg::*;

   count_type          total_ff, total_in;
   count_type          init_ff [SLICES];
   count_type          init_in [SLICES];
   count_type          count_ff [SLICES];
   count_type          count_in [SLICES];
   logic [CODE_W-1:0]  code_ff, code_in;
   logic               acc_ff, acc_in;
   count_type          out_ff [SLICES];
   count_type          out_in [SLICES];

   logic [SUM_W-1:0]   sum;
   logic               under;
   logic               over;
   logic [1:0]         pick_min;
   logic [1:0]         pick_max;
   logic               code_ok;
   logic               bal_done;
   digits_type         digits;

   // Code check and digit split of the held item.
   assign code_ok = code_ff < CODE_LIMIT;
   assign digits  = decode_code(code_ff);

   // Sum of the counts against the total, and the first smallest and largest slice.
   always_comb begin
      sum   = SUM_W'(count_ff[0]) + SUM_W'(count_ff[1]) + SUM_W'(count_ff[2]);
      under = sum < SUM_W'(total_ff);
      over  = sum > SUM_W'(total_ff);
      pick_min = 2'd0;
      if (count_ff[1] < count_ff[pick_min]) begin
         pick_min = 2'd1;
      end
      if (count_ff[2] < count_ff[pick_min]) begin
         pick_min = 2'd2;
      end
      pick_max = 2'd0;
      if (count_ff[1] > count_ff[pick_max]) begin
         pick_max = 2'd1;
      end
      if (count_ff[2] > count_ff[pick_max]) begin
         pick_max = 2'd2;
      end
      bal_done = !under && !(over && (count_ff[pick_max] > COUNT_MIN));
   end

   assign status.code_ok  = code_ok;
   assign status.bal_done = bal_done;

   // Next values of the registers.
   always_comb begin
      total_in = total_ff;
      code_in  = code_ff;
      acc_in   = acc_ff;
      for (int s = 0; s < SLICES; s++) begin
         init_in[s]  = init_ff[s];
         count_in[s] = count_ff[s];
         out_in[s]   = out_ff[s];
      end

      // Hold the code of an accepted item.
      if (cmd.take) begin
         code_in = req_action_code;
      end

      // Apply the per-slice change of a valid code, clamped to the count range.
      if (cmd.apply && code_ok) begin
         for (int s = 0; s < SLICES; s++) begin
            if (digits[s] == DIGIT_DEC) begin
               if (count_ff[s] > COUNT_MIN) begin
                  count_in[s] = count_ff[s] - 10'd1;
               end
            end else if (digits[s] == DIGIT_INC) begin
               if (count_ff[s] < COUNT_MAX) begin
                  count_in[s] = count_ff[s] + 10'd1;
               end
            end
         end
      end

      // Move one block toward the total.
      if (cmd.step && !bal_done) begin
         if (under) begin
            count_in[pick_min] = count_ff[pick_min] + 10'd1;
         end else begin
            count_in[pick_max] = count_ff[pick_max] - 10'd1;
         end
      end

      // Capture the result item.
      if (cmd.capture) begin
         acc_in = code_ok;
         for (int s = 0; s < SLICES; s++) begin
            out_in[s] = count_ff[s];
         end
      end

      // A configuration write updates one register and reloads all counts.
      if (csr_write_en) begin
         case (csr_index)
            CSR_TOTAL:  total_in   = csr_wdata;
            CSR_FIRST:  init_in[0] = csr_wdata;
            CSR_SECOND: init_in[1] = csr_wdata;
            CSR_THIRD:  init_in[2] = csr_wdata;
            default:    total_in   = total_ff;
         endcase
         for (int s = 0; s < SLICES; s++) begin
            count_in[s] = (init_in[s] == '0) ? COUNT_MIN : init_in[s];
         end
      end
   end

   // Configuration and count state.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= TOTAL_RESET;
         init_ff[0]  <= FIRST_RESET;
         init_ff[1]  <= SECOND_RESET;
         init_ff[2]  <= THIRD_RESET;
         count_ff[0] <= FIRST_RESET;
         count_ff[1] <= SECOND_RESET;
         count_ff[2] <= THIRD_RESET;
      end else begin
         total_ff <= total_in;
         for (int s = 0; s < SLICES; s++) begin
            init_ff[s]  <= init_in[s];
            count_ff[s] <= count_in[s];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      code_ff <= code_in;
      acc_ff  <= acc_in;
      for (int s = 0; s < SLICES; s++) begin
         out_ff[s] <= out_in[s];
      end
   end

   assign rsp_accepted     = acc_ff;
   assign rsp_count_first  = out_ff[0];
   assign rsp_count_second = out_ff[1];
   assign rsp_count_third  = out_ff[2];

endmodule

// ===== rtl/core/spas_ctrl.sv =====
// Controller: sequences accept, apply, rebalance and result hand-off for one item.
module spas_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  spas_pkg::spas_status_type  status,
   output spas_pkg::spas_cmd_type     cmd
);
   import spas_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_BALANCE,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can load when empty or when its item leaves this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = status.code_ok ? ST_BALANCE : ST_DONE;
         end
         ST_BALANCE: begin
            if (status.bal_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.capture  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/slice_prb_allocation_stepper.sv =====
// Top level of the slice resource-block allocation stepper.
// Each item runs through accept, apply, rebalance and result hand-off before the next
// item can be accepted; the rebalancing moves k single blocks, where after a balanced
// start k is at most three, but after a configuration reload with a mismatched total
// k can reach about three thousand. The rebalancing unit moves one block per cycle. A
// rejected code (27 or more) skips the rebalancing. The result sits in an output
// register, so a new item is accepted while the previous result waits.
// A configuration write reloads all three counts from the initial registers.
module slice_prb_allocation_stepper (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [spas_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [spas_pkg::COUNT_W-1:0]        csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [spas_pkg::CODE_W-1:0]         req_action_code,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_accepted,
   output logic [spas_pkg::COUNT_W-1:0]        rsp_count_first,
   output logic [spas_pkg::COUNT_W-1:0]        rsp_count_second,
   output logic [spas_pkg::COUNT_W-1:0]        rsp_count_third
);
   import spas_pkg::*;

   spas_cmd_type    cmd;
   spas_status_type status;

   // Sequencing of one item.
   spas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Registers, counts and rebalancing arithmetic.
   spas_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_action_code  (req_action_code),
      .cmd              (cmd),
      .status           (status),
      .rsp_accepted     (rsp_accepted),
      .rsp_count_first  (rsp_count_first),
      .rsp_count_second (rsp_count_second),
      .rsp_count_third  (rsp_count_third)
   );

endmodule

// ===== rtl/core/spas_checker.sv =====
// Port-level checks for the slice allocation stepper, bound to the top level.
module spas_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                csr_write_en,
   input logic [spas_pkg::CSR_IDX_W-1:0]      csr_index,
   input logic [spas_pkg::COUNT_W-1:0]        csr_wdata,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [spas_pkg::CODE_W-1:0]         req_action_code,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_accepted,
   input logic [spas_pkg::COUNT_W-1:0]        rsp_count_first,
   input logic [spas_pkg::COUNT_W-1:0]        rsp_count_second,
   input logic [spas_pkg::COUNT_W-1:0]        rsp_count_third
);
   import spas_pkg::*;

   // No result is shown right after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One item at a time: the input stalls right after an item is accepted.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after an item was accepted");

   // Every reported count is at least one.
   a_counts_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count_first != '0 && rsp_count_second != '0
                     && rsp_count_third != '0))
      else $error("reported count is zero");

   // A stalled result holds its item.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_accepted)
         && $stable(rsp_count_first) && $stable(rsp_count_second)
         && $stable(rsp_count_third)))
      else $error("stalled result changed");

endmodule

bind slice_prb_allocation_stepper spas_checker u_spas_checker (.*);
